@@ src/tsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, codes and the CRC-8 step for the scratchpad checker.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int INDEX_W     = 4;

    localparam logic [INDEX_W-1:0] LAST_INDEX   = INDEX_W'(FRAME_BYTES - 1);
    localparam logic [INDEX_W-1:0] IDX_TEMP_LO  = 4'd0;
    localparam logic [INDEX_W-1:0] IDX_TEMP_HI  = 4'd1;
    localparam logic [INDEX_W-1:0] IDX_CONFIG   = 4'd4;
    localparam logic [INDEX_W-1:0] IDX_COUNT    = 4'd6;

    localparam logic [7:0] FAM_EXTENDED  = 8'h10;
    localparam logic [7:0] FAM_MASKED_A  = 8'h28;
    localparam logic [7:0] FAM_MASKED_B  = 8'h22;
    localparam logic [7:0] CRC_POLY_REFL = 8'h8c;

    localparam logic [1:0] KIND_PLAIN    = 2'd0;
    localparam logic [1:0] KIND_EXTENDED = 2'd1;
    localparam logic [1:0] KIND_MASKED   = 2'd2;

    localparam logic [1:0] RES_9BIT  = 2'd0;
    localparam logic [1:0] RES_10BIT = 2'd1;
    localparam logic [1:0] RES_11BIT = 2'd2;
    localparam logic [1:0] RES_12BIT = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERROR = 2'd1;
    localparam logic [1:0] STATUS_BAD_VALUE = 2'd2;

    localparam logic signed [17:0] TEMP_MIN = -18'sd550;
    localparam logic signed [17:0] TEMP_MAX = 18'sd1200;

    typedef struct packed {
        logic       crc_ok;
        logic [1:0] kind;
        logic [1:0] res_field;
        logic [7:0] temp_low;
        logic [7:0] temp_high;
        logic [7:0] count_remain;
    } frame_t;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            fb  = crc[0] ^ b[i];
            crc = {1'b0, crc[7:1]};
            if (fb)
            begin
                crc = crc ^ CRC_POLY_REFL;
            end
        end
        return crc;
    endfunction

endpackage

@@ src/temp_scratchpad_check_convert.sv @@
// ----------------------------------------------------------------------------
// temp_scratchpad_check_convert
// Each frame passes the queue, stage A registers and output registers.
// Throughput: one byte per cycle unless the ninth byte meets a full two-entry
// frame queue; otherwise the front CRC unit and capture registers take a byte
// each cycle, and the back stage one frame per cycle while out_ready is high.
// Reset: rst_n clears the CRC, byte index, captured bytes and held value.
// ----------------------------------------------------------------------------
module temp_scratchpad_check_convert (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         scratch_byte,
    input  logic [7:0]         family_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [11:0] temp_decicelsius
);
    import tsc_pkg::*;

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;
    frame_t push_frame;
    frame_t pop_frame;

    tsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .scratch_byte (scratch_byte),
        .family_code  (family_code),
        .q_full       (q_full),
        .push         (push),
        .push_frame   (push_frame)
    );

    tsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .pop_frame  (pop_frame)
    );

    tsc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .pop_frame        (pop_frame),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .temp_decicelsius (temp_decicelsius)
    );

endmodule

@@ src/tsc_front.sv @@
// ----------------------------------------------------------------------------
// tsc_front
// Accepts scratchpad bytes, runs the CRC and emits one frame record per frame.
// ----------------------------------------------------------------------------
module tsc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      scratch_byte,
    input  logic [7:0]      family_code,
    input  logic            q_full,
    output logic            push,
    output tsc_pkg::frame_t push_frame
);
    import tsc_pkg::*;

    logic [7:0]         crc_reg;
    logic [7:0]         crc_next;
    logic [INDEX_W-1:0] index_reg;
    logic [7:0]         temp_low_reg;
    logic [7:0]         temp_high_reg;
    logic [7:0]         config_reg;
    logic [7:0]         count_reg;
    logic               last;
    logic               accept;

    assign last     = (index_reg == LAST_INDEX);
    assign in_ready = !(last && q_full);
    assign accept   = in_valid && in_ready;
    assign crc_next = crc_byte(crc_reg, scratch_byte);
    assign push     = accept && last;

    always_comb
    begin
        push_frame.crc_ok       = (crc_next == 8'd0);
        push_frame.res_field    = config_reg[6:5];
        push_frame.temp_low     = temp_low_reg;
        push_frame.temp_high    = temp_high_reg;
        push_frame.count_remain = count_reg;
        if (family_code == FAM_EXTENDED)
        begin
            push_frame.kind = KIND_EXTENDED;
        end
        else if (family_code == FAM_MASKED_A || family_code == FAM_MASKED_B)
        begin
            push_frame.kind = KIND_MASKED;
        end
        else
        begin
            push_frame.kind = KIND_PLAIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= 8'd0;
            index_reg     <= '0;
            temp_low_reg  <= 8'd0;
            temp_high_reg <= 8'd0;
            config_reg    <= 8'd0;
            count_reg     <= 8'd0;
        end
        else if (accept)
        begin
            if (last)
            begin
                crc_reg   <= 8'd0;
                index_reg <= '0;
            end
            else
            begin
                crc_reg   <= crc_next;
                index_reg <= index_reg + INDEX_W'(1);
            end
            if (index_reg == IDX_TEMP_LO)
            begin
                temp_low_reg <= scratch_byte;
            end
            if (index_reg == IDX_TEMP_HI)
            begin
                temp_high_reg <= scratch_byte;
            end
            if (index_reg == IDX_CONFIG)
            begin
                config_reg <= scratch_byte;
            end
            if (index_reg == IDX_COUNT)
            begin
                count_reg <= scratch_byte;
            end
        end
    end

endmodule

@@ src/tsc_queue.sv @@
// ----------------------------------------------------------------------------
// tsc_queue
// Two-entry queue of frame records between the front and back parts.
// ----------------------------------------------------------------------------
module tsc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsc_pkg::frame_t push_frame,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output tsc_pkg::frame_t pop_frame
);
    import tsc_pkg::*;

    frame_t     mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign pop_frame = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ src/tsc_back.sv @@
// ----------------------------------------------------------------------------
// tsc_back
// Converts frame records to tenths of a degree, range checks, holds the result.
// ----------------------------------------------------------------------------
module tsc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  tsc_pkg::frame_t   pop_frame,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic signed [11:0] temp_decicelsius
);
    import tsc_pkg::*;

    logic        a_valid_reg;
    logic        a_crc_ok_reg;
    logic        a_neg_reg;
    logic [15:0] a_mag_reg;
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [11:0] temp_reg;
    logic [11:0] held_reg;

    logic        a_advance;
    logic [15:0] m_raw;
    logic [15:0] m_ext;
    logic [15:0] m_abs;
    logic [15:0] m_masked;
    logic        neg;
    logic [15:0] int_scaled;
    logic [6:0]  frac_sum;
    logic [15:0] mag;
    logic signed [17:0] t_val;
    logic        good;

    assign a_advance = a_valid_reg && (!out_valid_reg || out_ready);
    assign pop       = q_valid && (!a_valid_reg || a_advance);

    always_comb
    begin
        m_raw = {pop_frame.temp_high, pop_frame.temp_low};
        if (pop_frame.kind == KIND_EXTENDED)
        begin
            m_ext = {m_raw[12:1], 4'd0} + 16'd12 - {8'd0, pop_frame.count_remain};
        end
        else
        begin
            m_ext = m_raw;
        end
        neg   = m_ext[15];
        m_abs = neg ? (16'd0 - m_ext) : m_ext;
        m_masked = m_abs;
        if (pop_frame.kind == KIND_MASKED)
        begin
            unique case (pop_frame.res_field)
                RES_9BIT:  m_masked = {m_abs[15:3], 3'd0};
                RES_10BIT: m_masked = {m_abs[15:2], 2'd0};
                RES_11BIT: m_masked = {m_abs[15:1], 1'd0};
                RES_12BIT: m_masked = m_abs;
            endcase
        end
    end

    always_comb
    begin
        int_scaled = {a_mag_reg[15:4], 4'd0} >> 3;
        int_scaled = int_scaled + ({4'd0, a_mag_reg[15:4]} << 3);
        frac_sum   = {3'd0, a_mag_reg[3:0]} * 7'd5 + (a_neg_reg ? 7'd0 : 7'd4);
        mag        = int_scaled + {12'd0, frac_sum[6:3]};
        t_val      = a_neg_reg ? (18'sd0 - $signed({2'b00, mag})) : $signed({2'b00, mag});
        good       = (t_val >= TEMP_MIN) && (t_val <= TEMP_MAX);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_crc_ok_reg <= pop_frame.crc_ok;
            a_neg_reg    <= neg;
            a_mag_reg    <= m_masked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_OK;
            temp_reg      <= 12'd0;
            held_reg      <= 12'd0;
        end
        else
        begin
            if (pop)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_advance)
            begin
                out_valid_reg <= 1'b1;
                priority if (!a_crc_ok_reg)
                begin
                    status_reg <= STATUS_CRC_ERROR;
                    temp_reg   <= held_reg;
                end
                else if (good)
                begin
                    status_reg <= STATUS_OK;
                    temp_reg   <= t_val[11:0];
                    held_reg   <= t_val[11:0];
                end
                else
                begin
                    status_reg <= STATUS_BAD_VALUE;
                    temp_reg   <= held_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign temp_decicelsius = $signed(temp_reg);

endmodule

@@ verif/scratchpad_reading_checker.sv @@
// ----------------------------------------------------------------------------
// scratchpad_reading_checker
// Watches both channels of the scratchpad checker, rebuilds each frame byte by
// byte, works out the status and held temperature that frame should produce,
// and compares every result transaction against the oldest reading still due.
// ----------------------------------------------------------------------------
module scratchpad_reading_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         scratch_byte,
    input  logic [7:0]         family_code,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         status,
    input  logic signed [11:0] temp_decicelsius,
    output int                 readings_due_count,
    output int                 mismatches
);
    import tsc_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [11:0] temp;
    } reading_t;

    reading_t           readings_due [$];
    reading_t           want;
    logic [7:0]         crc_acc;
    logic [3:0]         byte_pos;
    logic [7:0]         lo_byte;
    logic [7:0]         hi_byte;
    logic [7:0]         config_byte;
    logic [7:0]         remain_byte;
    logic signed [11:0] last_good;
    int                 tenths;

    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0] ^ data[k])
            begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic int decicelsius(input logic [7:0] fam, input logic [7:0] lo,
                                       input logic [7:0] hi, input logic [7:0] cfg,
                                       input logic [7:0] cnt);
        logic [15:0] m;
        logic        neg;
        int          mag;
        m = {hi, lo};
        if (fam == FAM_EXTENDED)
        begin
            m = ({m[15:1], 1'b0} << 3) + 16'd12 - {8'd0, cnt};
        end
        neg = m[15];
        if (neg)
        begin
            m = 16'd0 - m;
        end
        if (fam == FAM_MASKED_A || fam == FAM_MASKED_B)
        begin
            case (cfg[6:5])
                RES_9BIT:  m[2:0] = 3'b000;
                RES_10BIT: m[1:0] = 2'b00;
                RES_11BIT: m[0]   = 1'b0;
                default:   ;
            endcase
        end
        mag = int'(m[15:4]) * 10 + (int'(m[3:0]) * 640 + (neg ? 0 : 512)) / 1024;
        return neg ? -mag : mag;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_acc     = 8'd0;
            byte_pos    = 4'd0;
            lo_byte     = 8'd0;
            hi_byte     = 8'd0;
            config_byte = 8'd0;
            remain_byte = 8'd0;
            last_good   = 12'sd0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("result with no frame due: status %0d, temp_decicelsius %0d",
                           status, temp_decicelsius);
                    mismatches++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatches++;
                    end
                    if (temp_decicelsius !== want.temp)
                    begin
                        $error("temp_decicelsius: expected %0d, actual %0d",
                               want.temp, temp_decicelsius);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                crc_acc = crc8_update(crc_acc, scratch_byte);
                case (byte_pos)
                    IDX_TEMP_LO: lo_byte     = scratch_byte;
                    IDX_TEMP_HI: hi_byte     = scratch_byte;
                    IDX_CONFIG:  config_byte = scratch_byte;
                    IDX_COUNT:   remain_byte = scratch_byte;
                    default:     ;
                endcase
                if (byte_pos == LAST_INDEX)
                begin
                    if (crc_acc != 8'd0)
                    begin
                        want.status = STATUS_CRC_ERROR;
                    end
                    else
                    begin
                        tenths = decicelsius(family_code, lo_byte, hi_byte, config_byte,
                                             remain_byte);
                        if (tenths < int'(TEMP_MIN) || tenths > int'(TEMP_MAX))
                        begin
                            want.status = STATUS_BAD_VALUE;
                        end
                        else
                        begin
                            last_good   = 12'(tenths);
                            want.status = STATUS_OK;
                        end
                    end
                    want.temp = last_good;
                    readings_due.push_back(want);
                    byte_pos = 4'd0;
                    crc_acc  = 8'd0;
                end
                else
                begin
                    byte_pos = byte_pos + 4'd1;
                end
            end
            readings_due_count = readings_due.size();
        end
    end

endmodule

@@ verif/temp_scratchpad_check_convert_test.sv @@
// ----------------------------------------------------------------------------
// temp_scratchpad_check_convert_test
// Feeds scratchpad frames into the checker/converter: a directed set of
// temperature, family, resolution and CRC corner cases, then random sealed
// frames, corrupted frames and noise, with random gaps and stalls on both
// channels. Prediction and comparison happen in scratchpad_reading_checker.
// ----------------------------------------------------------------------------
module temp_scratchpad_check_convert_test;
    import tsc_pkg::*;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [7:0]         scratch_byte = 8'd0;
    logic [7:0]         family_code  = 8'd0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [1:0]         status;
    logic signed [11:0] temp_decicelsius;

    int                 readings_pending;
    int                 mismatches;
    bit                 calm = 1'b0;
    logic [7:0]         frame [0:8];

    always #10 clk = ~clk;

    temp_scratchpad_check_convert dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .scratch_byte     (scratch_byte),
        .family_code      (family_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .temp_decicelsius (temp_decicelsius)
    );

    scratchpad_reading_checker u_reading_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .scratch_byte       (scratch_byte),
        .family_code        (family_code),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .temp_decicelsius   (temp_decicelsius),
        .readings_due_count (readings_pending),
        .mismatches         (mismatches)
    );

    task automatic send_byte(input logic [7:0] data, input logic [7:0] fam);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        scratch_byte <= data;
        family_code  <= fam;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // earlier bytes carry random family codes; only the last one counts
    task automatic send_frame(input logic [7:0] fam);
        for (int i = 0; i < 8; i++)
        begin
            send_byte(frame[i], 8'($urandom));
        end
        send_byte(frame[8], fam);
    endtask

    task automatic send_reading(input logic [7:0] fam, input logic [15:0] raw,
                                input logic [7:0] cfg, input logic [7:0] cnt,
                                input bit corrupt);
        logic [7:0] crc;
        for (int i = 0; i < 9; i++)
        begin
            frame[i] = 8'($urandom);
        end
        frame[IDX_TEMP_LO] = raw[7:0];
        frame[IDX_TEMP_HI] = raw[15:8];
        frame[IDX_CONFIG]  = cfg;
        frame[IDX_COUNT]   = cnt;
        crc = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            crc = crc_byte(crc, frame[i]);
        end
        frame[8] = corrupt ? crc ^ (8'd1 << $urandom_range(0, 7)) : crc;
        send_frame(fam);
    endtask

    initial
    begin
        int stall;
        int results_taken;
        results_taken = 0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (results_taken == 30)
            begin
                stall = 150;
            end
            repeat (stall)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            results_taken++;
        end
    end

    initial
    begin
        #3000000;
        $display("temp_scratchpad_check_convert_test: errors");
        $finish;
    end

    initial
    begin
        int          pick;
        logic [7:0]  fam;
        logic [15:0] raw;
        logic [7:0]  cnt;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        send_reading(8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
        send_reading(8'hff, 16'h0780, 8'hff, 8'hff, 1'b0);
        send_reading(FAM_MASKED_A, 16'h07d0, 8'h7f, 8'h00, 1'b0);
        send_reading(FAM_MASKED_B, 16'hfc90, 8'h00, 8'h00, 1'b0);
        send_reading(8'h01, 16'hfc8f, 8'h00, 8'h00, 1'b0);
        send_reading(8'h01, 16'hfc8e, 8'h00, 8'h00, 1'b0);
        send_reading(FAM_MASKED_A, 16'h0197, 8'h20, 8'h00, 1'b0);
        send_reading(FAM_MASKED_A, 16'hff5f, 8'h40, 8'h00, 1'b0);
        send_reading(FAM_MASKED_B, 16'h00af, 8'h60, 8'h00, 1'b0);
        send_reading(FAM_EXTENDED, 16'h00aa, 8'h00, 8'h0c, 1'b0);
        send_reading(FAM_EXTENDED, 16'h00aa, 8'h00, 8'hff, 1'b0);
        send_reading(FAM_EXTENDED, 16'hff92, 8'h00, 8'h05, 1'b0);
        send_reading(8'h00, 16'h8000, 8'h00, 8'h00, 1'b0);
        send_reading(FAM_MASKED_B, 16'h0190, 8'h60, 8'h00, 1'b1);
        for (int i = 0; i < 9; i++)
        begin
            frame[i] = 8'hff;
        end
        send_frame(8'hff);

        for (int n = 0; n < 158; n++)
        begin
            calm = (n >= 30 && n < 50) || (n >= 110 && n < 125);
            if (n == 80)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (readings_pending != 0) @(negedge clk);
            end
            pick = $urandom_range(0, 9);
            case ($urandom_range(0, 3))
                0:       fam = FAM_EXTENDED;
                1:       fam = FAM_MASKED_A;
                2:       fam = FAM_MASKED_B;
                default: fam = 8'($urandom);
            endcase
            if (fam == FAM_EXTENDED)
            begin
                raw = 16'($urandom_range(0, 380)) - 16'd130;
                cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
            end
            else
            begin
                raw = 16'($urandom_range(0, 2900)) - 16'd940;
                cnt = 8'($urandom);
            end
            if (pick == 7)
            begin
                raw = 16'($urandom);
            end
            if (pick == 9)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    frame[i] = 8'($urandom);
                end
                send_frame(fam);
            end
            else
            begin
                send_reading(fam, raw, 8'($urandom), cnt, pick == 8);
            end
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (readings_pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("temp_scratchpad_check_convert_test: clean");
        end
        else
        begin
            $display("temp_scratchpad_check_convert_test: errors");
        end
        $finish;
    end

endmodule
